// ===== sv/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg - shared types and constants of the first-fit chunk allocator
// Chunk table entry, the travelling request packet, command and status codes.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int MAX_CHUNKS   = 64;
  localparam int REGION_BYTES = 1048576;
  localparam int ALIGN_BYTES  = 16;

  localparam int ADDR_W = 20;  // chunk offset
  localparam int LEN_W  = 21;  // chunk length
  localparam int REQ_W  = 21;  // requested bytes
  localparam int SIZE_W = 22;  // rounded size, may carry past REQ_W
  localparam int ST_W   = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [ST_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO_SIZE  = 3'd4;

  localparam logic [1:0] SHIFT_NONE = 2'd0;
  localparam logic [1:0] SHIFT_ONE  = 2'd1;
  localparam logic [1:0] SHIFT_TWO  = 2'd2;

  typedef struct packed {
    logic              vld;
    logic              used;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ent_t;

  // request travelling down the cell row, one cell per cycle while the row advances
  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;   // free offset in, chunk offset out
    logic              done;
    logic [ST_W-1:0]   status;
    logic [1:0]        shift;  // entries removed by a merge
    ent_t              carry;  // entry being pushed right by a split
  } pkt_t;

endpackage

// ===== sv/ffca_cell.sv =====
// ----------------------------------------------------------------------------
// ffca_cell - one chunk table entry
// Acts on the request packet as it passes: fit test, split, free and merge,
// and the ripple of an insertion or a removal through the row.
// ----------------------------------------------------------------------------
module ffca_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,        // row advances this cycle
  input  logic            last_full,  // last cell of the row holds an entry
  input  ffca_pkg::ent_t  rst_ent_i,
  input  ffca_pkg::pkt_t  pkt_i,
  input  ffca_pkg::ent_t  n1_i,       // right neighbour
  input  ffca_pkg::ent_t  n2_i,       // neighbour after that
  output ffca_pkg::pkt_t  pkt_o,
  output ffca_pkg::ent_t  ent_o
);

  ffca_pkg::ent_t ent_r, ent_nxt;
  ffca_pkg::pkt_t pkt_r, pkt_nxt;
  logic [ffca_pkg::SIZE_W-1:0] len_x;

  assign len_x = ffca_pkg::SIZE_W'(ent_r.len);

  always_comb begin
    ent_nxt = ent_r;
    pkt_nxt = pkt_i;
    if (pkt_i.vld) begin
      if (pkt_i.shift == ffca_pkg::SHIFT_ONE) begin
        ent_nxt = n1_i;
      end else if (pkt_i.shift == ffca_pkg::SHIFT_TWO) begin
        ent_nxt = n2_i;
      end else if (pkt_i.carry.vld) begin
        ent_nxt       = pkt_i.carry;
        pkt_nxt.carry = ent_r;
      end else if (!pkt_i.done) begin
        if (pkt_i.cmd == ffca_pkg::CMD_ALLOC) begin
          if (ent_r.vld && !ent_r.used && len_x >= pkt_i.size) begin
            pkt_nxt.done = 1'b1;
            if (len_x == pkt_i.size) begin
              ent_nxt.used   = 1'b1;
              pkt_nxt.status = ffca_pkg::ST_OK;
              pkt_nxt.addr   = ent_r.start;
            end else if (last_full) begin
              pkt_nxt.status = ffca_pkg::ST_TABLE_FULL;
            end else begin
              ent_nxt.used        = 1'b1;
              ent_nxt.len         = ffca_pkg::LEN_W'(pkt_i.size);
              pkt_nxt.carry.vld   = 1'b1;
              pkt_nxt.carry.used  = 1'b0;
              pkt_nxt.carry.start = ent_r.start + ffca_pkg::ADDR_W'(pkt_i.size);
              pkt_nxt.carry.len   = ffca_pkg::LEN_W'(len_x - pkt_i.size);
              pkt_nxt.status      = ffca_pkg::ST_OK;
              pkt_nxt.addr        = ent_r.start;
            end
          end
        end else begin
          if (ent_r.vld && ent_r.used && ent_r.start == pkt_i.addr) begin
            // freed here, absorb a free right neighbour
            ent_nxt.used   = 1'b0;
            pkt_nxt.done   = 1'b1;
            pkt_nxt.status = ffca_pkg::ST_OK;
            if (n1_i.vld && !n1_i.used) begin
              ent_nxt.len   = ent_r.len + n1_i.len;
              pkt_nxt.shift = ffca_pkg::SHIFT_ONE;
            end
          end else if (ent_r.vld && !ent_r.used && n1_i.vld && n1_i.used &&
                       n1_i.start == pkt_i.addr) begin
            // free chunk followed by the one being freed
            pkt_nxt.done   = 1'b1;
            pkt_nxt.status = ffca_pkg::ST_OK;
            if (n2_i.vld && !n2_i.used) begin
              ent_nxt.len   = ent_r.len + n1_i.len + n2_i.len;
              pkt_nxt.shift = ffca_pkg::SHIFT_TWO;
            end else begin
              ent_nxt.len   = ent_r.len + n1_i.len;
              pkt_nxt.shift = ffca_pkg::SHIFT_ONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= rst_ent_i;
      pkt_r <= '0;
    end else if (adv) begin
      ent_r <= ent_nxt;
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;
  assign ent_o = ent_r;

endmodule

// ===== sv/first_fit_chunk_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator - first-fit allocator over one fixed region
// Address-ordered chunk table held in a row of cells; requests travel it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transfer. cmd 0 allocates req_size bytes (rounded
//           up to 16), cmd 1 frees the used chunk at free_address.
//   out_* : one result per request: address and status (0 ok, 1 no space,
//           2 not found, 3 table full, 4 zero size). address is 0 unless ok.
//   Each request enters cell 0 at its accepting edge and moves one cell per
//   cycle down the MAX_CHUNKS cells of the table; a split pushes entries
//   right and a merge pulls them left as it goes. The result is registered
//   as the request leaves the last cell, and the next request is taken
//   only after that: no new request is taken while one walks the row.
//   Reset (synchronous, rst_n low) leaves one free chunk spanning the region.
//   If the receiver stalls with a result still held, a new request may still
//   be taken; it walks the row and waits at its end until the output
//   register is free.
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cmd[0], req_size[21:1], free_address[41:22]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // address[19:0], status[22:20]
);

  localparam int N = ffca_pkg::MAX_CHUNKS;

  ffca_pkg::pkt_t pkts [N];
  ffca_pkg::ent_t ents [N];
  ffca_pkg::pkt_t inj;
  ffca_pkg::pkt_t tail;
  ffca_pkg::ent_t ent_none;
  ffca_pkg::ent_t ent_first;
  ffca_pkg::ent_t ent_empty;

  logic                         busy_r, busy_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic [ffca_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [ffca_pkg::ST_W-1:0]    out_st_r, out_st_nxt;
  logic                         accept, adv, exit_now;
  logic [ffca_pkg::REQ_W-1:0]   req;
  logic [ffca_pkg::SIZE_W-1:0]  rsize;
  logic [N-1:0]                 pkt_vlds;

  assign ent_none  = '0;
  assign ent_empty = '0;
  assign ent_first = '{vld: 1'b1, used: 1'b0, start: '0,
                       len: ffca_pkg::LEN_W'(ffca_pkg::REGION_BYTES)};

  assign accept = in_tvalid && in_tready;
  assign req    = in_tdata[21:1];
  // round up to the alignment granule
  assign rsize  = (ffca_pkg::SIZE_W'(req) + ffca_pkg::SIZE_W'(ffca_pkg::ALIGN_BYTES - 1))
                  & ~ffca_pkg::SIZE_W'(ffca_pkg::ALIGN_BYTES - 1);

  always_comb begin
    inj        = '0;
    inj.vld    = accept;
    inj.cmd    = in_tdata[0];
    inj.size   = rsize;
    inj.addr   = in_tdata[41:22];
    inj.status = ffca_pkg::ST_OK;
    if (in_tdata[0] == ffca_pkg::CMD_ALLOC && req == '0) begin
      inj.done   = 1'b1;
      inj.status = ffca_pkg::ST_ZERO_SIZE;
    end
  end

  assign tail = pkts[N-1];
  // row holds still only while a finished request waits for the output slot
  assign adv      = !(tail.vld && out_vld_r && !out_tready);
  assign exit_now = tail.vld && adv;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      ffca_pkg::ent_t n1, n2;
      if (k + 1 < N) begin : g_n1
        assign n1 = ents[k+1];
      end else begin : g_n1_end
        assign n1 = ent_none;
      end
      if (k + 2 < N) begin : g_n2
        assign n2 = ents[k+2];
      end else begin : g_n2_end
        assign n2 = ent_none;
      end
      assign pkt_vlds[k] = pkts[k].vld;
      ffca_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .last_full (ents[N-1].vld),
        .rst_ent_i ((k == 0) ? ent_first : ent_empty),
        .pkt_i     ((k == 0) ? inj : pkts[(k == 0) ? 0 : k-1]),
        .n1_i      (n1),
        .n2_i      (n2),
        .pkt_o     (pkts[k]),
        .ent_o     (ents[k])
      );
    end
  endgenerate

  always_comb begin
    busy_nxt     = busy_r;
    out_vld_nxt  = out_vld_r;
    out_addr_nxt = out_addr_r;
    out_st_nxt   = out_st_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (exit_now) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      if (tail.done) begin
        out_st_nxt = tail.status;
      end else if (tail.cmd == ffca_pkg::CMD_ALLOC) begin
        out_st_nxt = ffca_pkg::ST_NO_SPACE;
      end else begin
        out_st_nxt = ffca_pkg::ST_NOT_FOUND;
      end
      out_addr_nxt = (tail.done && tail.status == ffca_pkg::ST_OK) ? tail.addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign in_tready  = !busy_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_st_r, out_addr_r};

  // only one request ever walks the row
  a_one_pkt: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(pkt_vlds))
    else $error("more than one request in the cell row");

  // table head always starts at offset zero
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    ents[0].vld && ents[0].start == '0)
    else $error("table head lost");

  // a result appears only as a request leaves the row
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy_r))
    else $error("result without request");

  // the last cell holds a request whenever a request ends
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(tail.vld))
    else $error("request ended away from the row end");

endmodule
